// ===== hdl/ngt_pkg.sv =====
// ----------------------------------------------------------------------------
// ngt_pkg
// Types, codes and helpers shared by the gather (take) engine.
// ----------------------------------------------------------------------------
package ngt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned NULLS_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TAKE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_CHECK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH  = 2'd1;

  localparam logic [2:0] WIDTH_1  = 3'd0;
  localparam logic [2:0] WIDTH_8  = 3'd1;
  localparam logic [2:0] WIDTH_16 = 3'd2;
  localparam logic [2:0] WIDTH_32 = 3'd3;
  localparam logic [2:0] WIDTH_64 = 3'd4;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [VALUE_W-1:0]        load_value;
    logic                      load_value_valid;
    logic signed [INDEX_W-1:0] take_index;
    logic                      index_valid;
    logic                      batch_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] gathered_value;
    logic               gathered_valid;
    logic               bounds_error;
    logic               result_last;
    logic [NULLS_W-1:0] batch_null_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic take;
    logic finish;
  } cmd_t;

  function automatic logic [VALUE_W-1:0] width_mask(input logic [2:0] code);
    logic [VALUE_W-1:0] m;
    unique case (code)
      WIDTH_1:  m = VALUE_W'(64'h1);
      WIDTH_8:  m = VALUE_W'(64'hFF);
      WIDTH_16: m = VALUE_W'(64'hFFFF);
      WIDTH_32: m = VALUE_W'(64'hFFFF_FFFF);
      default:  m = '1;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/ngt_ram.sv =====
// ----------------------------------------------------------------------------
// ngt_ram
// Single-port RAM with registered read; read data holds between reads.
// ----------------------------------------------------------------------------
module ngt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ngt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngt_ctrl
// Controller: input handshake, table read wait and output register handshake.
// ----------------------------------------------------------------------------
module ngt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         req_type_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ngt_pkg::cmd_t      cmd_o
);
  import ngt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;

  assign in_stall_o = (state_q == S_READ);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.load   = in_acc & (req_type_i == REQ_LOAD);
    cmd_o.clear  = in_acc & (req_type_i == REQ_CLEAR);
    cmd_o.take   = in_acc & (req_type_i == REQ_TAKE);
    cmd_o.finish = (state_q == S_READ) & (~out_valid_q | ~out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.take) state_d = S_READ;
      S_READ: if (cmd_o.finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ngt_dp.sv =====
// ----------------------------------------------------------------------------
// ngt_dp
// Datapath: value table, entry count, batch counters and result register.
// ----------------------------------------------------------------------------
module ngt_dp #(
  parameter int unsigned TABLE_DEPTH = ngt_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ngt_pkg::cmd_t                  cmd_i,
  input  ngt_pkg::in_item_t              in_data_i,
  input  logic                           cfg_we_i,
  input  logic [ngt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ngt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ngt_pkg::out_item_t             out_data_o
);
  import ngt_pkg::*;

  localparam int unsigned RW = VALUE_W + 1;

  logic [CW-1:0]      count_q, count_d;
  logic [NULLS_W-1:0] nulls_q, nulls_d;
  logic               err_q, err_d;
  logic               bce_q;
  logic [2:0]         width_q;
  logic               idx_valid_q, in_range_q, last_q;
  out_item_t          out_q, out_d;

  logic               full;
  logic               in_range;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [RW-1:0]      ram_wdata, ram_rdata;
  logic               hit;
  logic               err_new;
  logic [NULLS_W-1:0] nulls_new;

  assign full     = (count_q == CW'(TABLE_DEPTH));
  assign in_range = ~in_data_i.take_index[INDEX_W-1] &&
                    ($unsigned(in_data_i.take_index) < INDEX_W'(count_q));

  assign ram_we    = cmd_i.load & ~full;
  assign ram_addr  = cmd_i.take ? in_data_i.take_index[AW-1:0] : count_q[AW-1:0];
  assign ram_wdata = {in_data_i.load_value_valid, in_data_i.load_value};

  ngt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.take),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (ram_we) begin
      count_d = count_q + CW'(1);
    end
  end

  always_comb begin
    hit       = idx_valid_q & in_range_q & ram_rdata[VALUE_W];
    err_new   = err_q | (idx_valid_q & ~in_range_q & bce_q);
    nulls_new = nulls_q;
    if (!hit && nulls_q != '1) begin
      nulls_new = nulls_q + NULLS_W'(1);
    end
    out_d.gathered_value   = hit ? (ram_rdata[VALUE_W-1:0] & width_mask(width_q)) : '0;
    out_d.gathered_valid   = hit;
    out_d.bounds_error     = err_new;
    out_d.result_last      = last_q;
    out_d.batch_null_count = nulls_new;

    nulls_d = nulls_q;
    err_d   = err_q;
    if (cmd_i.finish) begin
      nulls_d = last_q ? '0 : nulls_new;
      err_d   = last_q ? 1'b0 : err_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      nulls_q <= '0;
      err_q   <= 1'b0;
      bce_q   <= 1'b1;
      width_q <= WIDTH_64;
    end else begin
      count_q <= count_d;
      nulls_q <= nulls_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BOUNDS_CHECK: bce_q   <= cfg_data_i[0];
          CFG_VALUE_WIDTH:  width_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_valid_q <= in_data_i.index_valid;
      in_range_q  <= in_range;
      last_q      <= in_data_i.batch_last;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/nullable_gather_take.sv =====
// ----------------------------------------------------------------------------
// nullable_gather_take
// Columnar gather engine over a value table with validity bits.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries load, take and
// clear items; an item moves when valid is high and stall is low. Load and
// clear items give no result. A take item reads the table in the cycle it is
// accepted; the block then waits in its read state, with the input stalled,
// until the RAM's registered read data moves into the output register.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries one result
// per take. A result waiting in the output register does not block loads,
// clears or the next take's table read; only the move of a second result into
// the output register waits for the first to be taken.
// Configuration (cfg_we_i / cfg_index_i / cfg_data_i) writes bounds check
// enable (index 0) and value width code (index 1); the user must do so only
// while the block is idle, which the block itself does not enforce. Reset
// empties the table, clears the batch null count and error flag, sets bounds
// checking on and the value width to 64 bits.
// ----------------------------------------------------------------------------
module nullable_gather_take #(
  parameter int unsigned TABLE_DEPTH = ngt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ngt_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ngt_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ngt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ngt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ngt_pkg::*;

  cmd_t cmd;

  ngt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ngt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/nullable_gather_take_tb.sv =====
// ----------------------------------------------------------------------------
// nullable_gather_take_tb
// Self-checking bench for the columnar gather engine. Loads fill the value
// table, takes gather from it by signed index and clears empty it. Every
// accepted item is run through a cycle-free model of the table, the batch
// error flag and the null counter, and each result is checked field by field
// against the oldest prediction. The input idles and the receiver stalls in
// random bursts, the receiver once holds off for a long stretch, and the run
// walks all value width codes with bounds checking on and off.
// ----------------------------------------------------------------------------
module nullable_gather_take_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ngt_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  class gather_checker;
    bit [VALUE_W-1:0] values [DEPTH];
    bit               valids [DEPTH];
    int unsigned      entries;
    bit [NULLS_W-1:0] nulls;
    bit               error_flag;
    bit               bounds_check;
    bit [2:0]         width_code;
    out_item_t        expected_takes [$];
    int unsigned      mismatches;
    int unsigned      take_count, null_takes, oob_count;
    int unsigned      load_count, clear_count, ignored_count;

    function new();
      bounds_check = 1'b1;
      width_code   = WIDTH_64;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BOUNDS_CHECK) begin
        bounds_check = data[0];
      end else if (idx == CFG_VALUE_WIDTH) begin
        width_code = data;
      end
    endfunction

    function bit [VALUE_W-1:0] width_bits(bit [2:0] code);
      case (code)
        WIDTH_1:  return 64'h1;
        WIDTH_8:  return 64'hFF;
        WIDTH_16: return 64'hFFFF;
        WIDTH_32: return 64'hFFFF_FFFF;
        default:  return '1;
      endcase
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t              r;
      bit                     in_range;
      bit [INDEX_W-2:0]       pos;
      r   = '0;
      pos = it.take_index[INDEX_W-2:0];
      case (it.req_type)
        REQ_LOAD: begin
          if (entries < DEPTH) begin
            values[entries] = it.load_value;
            valids[entries] = it.load_value_valid;
            entries++;
            load_count++;
          end else begin
            ignored_count++;
          end
        end
        REQ_CLEAR: begin
          entries = 0;
          clear_count++;
        end
        REQ_TAKE: begin
          in_range = !it.take_index[INDEX_W-1] && (pos < entries);
          if (it.index_valid) begin
            if (in_range) begin
              if (valids[pos]) begin
                r.gathered_valid = 1'b1;
                r.gathered_value = values[pos] & width_bits(width_code);
              end
            end else begin
              oob_count++;
              if (bounds_check) begin
                error_flag = 1'b1;
              end
            end
          end
          if (!r.gathered_valid) begin
            null_takes++;
            if (nulls != '1) begin
              nulls++;
            end
          end
          r.bounds_error     = error_flag;
          r.result_last      = it.batch_last;
          r.batch_null_count = nulls;
          expected_takes.push_back(r);
          take_count++;
          if (it.batch_last) begin
            nulls      = '0;
            error_flag = 1'b0;
          end
        end
        default: begin
          ignored_count++;
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_takes.size() == 0) begin
        fail($sformatf("unexpected result: value=%h valid=%0b error=%0b last=%0b nulls=%0d",
                       got.gathered_value, got.gathered_valid, got.bounds_error,
                       got.result_last, got.batch_null_count));
        return;
      end
      want = expected_takes.pop_front();
      if (got.gathered_value !== want.gathered_value ||
          got.gathered_valid !== want.gathered_valid ||
          got.bounds_error !== want.bounds_error ||
          got.result_last !== want.result_last ||
          got.batch_null_count !== want.batch_null_count) begin
        fail($sformatf({"result mismatch: expected value=%h valid=%0b error=%0b last=%0b ",
                        "nulls=%0d, got value=%h valid=%0b error=%0b last=%0b nulls=%0d"},
                       want.gathered_value, want.gathered_valid, want.bounds_error,
                       want.result_last, want.batch_null_count,
                       got.gathered_value, got.gathered_valid, got.bounds_error,
                       got.result_last, got.batch_null_count));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gather_checker gathers;
  bit            idling_on;
  int            hold_request;
  int unsigned   table_fill;
  int unsigned   cycle_count;

  nullable_gather_take dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    idling_on    = 1'b0;
    hold_request = 0;
    table_fill   = 0;
    cycle_count  = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        gathers.note_item(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        gathers.check_result(out_data_o);
      end
    end
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type         = 2'($urandom);
    it.load_value       = {$urandom, $urandom};
    it.load_value_valid = 1'($urandom);
    it.take_index       = $urandom;
    it.index_valid      = 1'($urandom);
    it.batch_last       = 1'($urandom);
    return it;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return table_fill + $urandom_range(0, 3);
      1:       return -$urandom_range(1, 8);
      2:       return $urandom;
      default: return (table_fill > 0) ? $urandom_range(0, table_fill - 1)
                                       : $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (it.req_type == REQ_LOAD && table_fill < DEPTH) begin
      table_fill++;
    end else if (it.req_type == REQ_CLEAR) begin
      table_fill = 0;
    end
  endtask

  task automatic push_value(logic [VALUE_W-1:0] v, bit ok);
    in_item_t it;
    it                  = noise_item();
    it.req_type         = REQ_LOAD;
    it.load_value       = v;
    it.load_value_valid = ok;
    send(it);
  endtask

  task automatic take_at(logic signed [INDEX_W-1:0] idx, bit iv, bit last);
    in_item_t it;
    it             = noise_item();
    it.req_type    = REQ_TAKE;
    it.take_index  = idx;
    it.index_valid = iv;
    it.batch_last  = last;
    send(it);
  endtask

  task automatic clear_table();
    in_item_t it;
    it          = noise_item();
    it.req_type = REQ_CLEAR;
    send(it);
  endtask

  // drain results, then let the last load or clear settle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (gathers.expected_takes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gathers.write_reg(idx, data);
  endtask

  task automatic run_random(int target);
    int sent;
    int n;
    int k;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        clear_table();
        sent++;
      end
      n = $urandom_range(0, 12);
      repeat (n) push_value(random_value(), $urandom_range(0, 3) != 0);
      sent += n;
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          send(noise_item());
          sent++;
        end
        take_at(pick_index(), $urandom_range(0, 9) != 0,
                k == n - 1 || $urandom_range(0, 11) == 0);
      end
      sent += n;
    end
  endtask

  initial begin
    in_item_t odd;
    int       p;
    gathers = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_BOUNDS_CHECK, 3'd1);
    write_reg(CFG_VALUE_WIDTH, WIDTH_64);

    take_at(0, 1'b1, 1'b0);
    take_at(0, 1'b0, 1'b0);
    take_at(32'sh8000_0000, 1'b1, 1'b1);
    push_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    push_value(64'h0, 1'b1);
    push_value(64'h8000_0000_0000_0001, 1'b0);
    push_value(64'h0123_4567_89AB_CDEF, 1'b1);
    take_at(0, 1'b1, 1'b0);
    take_at(1, 1'b1, 1'b0);
    take_at(2, 1'b1, 1'b0);
    take_at(3, 1'b1, 1'b0);
    take_at(4, 1'b1, 1'b0);
    take_at(32'sh7FFF_FFFF, 1'b1, 1'b0);
    take_at(-1, 1'b1, 1'b0);
    take_at(3, 1'b0, 1'b1);
    take_at(9, 1'b1, 1'b0);
    clear_table();
    push_value(64'hA5, 1'b1);
    take_at(0, 1'b1, 1'b1);
    odd          = noise_item();
    odd.req_type = 2'b11;
    send(odd);
    write_reg(CFG_BOUNDS_CHECK, 3'd0);
    take_at(5, 1'b1, 1'b1);

    for (p = 0; p < 16; p++) begin
      idling_on = $urandom_range(0, 3) != 0;
      write_reg(CFG_BOUNDS_CHECK, 3'(p % 2));
      write_reg(CFG_VALUE_WIDTH, 3'(p / 2));
      run_random(60);
    end

    idling_on = 1'b0;
    write_reg(CFG_BOUNDS_CHECK, 3'd1);
    write_reg(CFG_VALUE_WIDTH, WIDTH_64);
    clear_table();
    repeat (16) push_value(random_value(), 1'b1);
    hold_request = 240;
    for (p = 0; p < 40; p++) begin
      take_at(pick_index(), 1'b1, p == 39);
    end

    write_reg(CFG_VALUE_WIDTH, WIDTH_16);
    run_random(200);

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d takes (%0d null, %0d out of range), %0d loads, %0d clears",
             gathers.take_count, gathers.null_takes, gathers.oob_count,
             gathers.load_count, gathers.clear_count);
    $display("plus %0d ignored items, all width codes, bounds check on and off",
             gathers.ignored_count);
    if (gathers.mismatches == 0 && gathers.expected_takes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ngt_pkg.sv
hdl/ngt_ram.sv
hdl/ngt_ctrl.sv
hdl/ngt_dp.sv
hdl/nullable_gather_take.sv
bench/nullable_gather_take_tb.sv
